// ----- rtl/wsbh_pkg.sv -----
package wsbh_pkg;

  // Fixed widths of the item fields and of the arithmetic.
  localparam int unsigned DataWidth = 32;
  localparam int unsigned ByteWidth = 8;

  // Default for the position counter width.
  localparam int unsigned PositionBitsDefault = 16;

  // The remainder unit retires one dividend bit per step.
  localparam int unsigned DivSteps = DataWidth;

  // Register map: index i lies at byte address 4*i.
  localparam int unsigned AddrWidth = 3;
  localparam logic RegTableSize = 1'b0;
  localparam logic RegFoldCase  = 1'b1;

  // Register reset values.
  localparam logic [DataWidth-1:0] TableSizeReset = 32'd256;
  localparam logic                 FoldCaseReset  = 1'b0;

  // ASCII case folding.
  localparam logic [ByteWidth-1:0] AsciiUpperFirst = 8'h41;
  localparam logic [ByteWidth-1:0] AsciiUpperLast  = 8'h5A;
  localparam logic [ByteWidth-1:0] AsciiCaseOffset = 8'h20;

  typedef struct packed {
    logic [ByteWidth-1:0] char_byte;
    logic                 last_byte;
  } in_item_t;

  typedef struct packed {
    logic [DataWidth-1:0] bucket;
    logic                 overlong;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accum;     // a byte that is not last was taken
    logic finish;    // the last byte was taken: close the sum, start the remainder
    logic div_step;  // one restoring remainder step
    logic load_out;  // move the finished remainder into the output register
  } dp_cmd_t;

endpackage

// ----- rtl/wsbh_ctrl.sv -----
module wsbh_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  logic              out_stall_i,
  output logic              in_stall_o,
  output logic              out_valid_o,
  output wsbh_pkg::dp_cmd_t cmd_o
);
  import wsbh_pkg::*;

  localparam int unsigned CntWidth = $clog2(DivSteps);
  localparam logic [CntWidth-1:0] CntLast = CntWidth'(DivSteps - 1);

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                out_valid_q, out_valid_d;
  logic                in_take;
  logic                out_take;
  logic                out_free;

  assign in_stall_o  = (state_q != ST_RUN);
  assign out_valid_o = out_valid_q;
  assign in_take     = in_valid_i && (state_q == ST_RUN);
  assign out_take    = out_valid_q && !out_stall_i;
  assign out_free    = !out_valid_q || out_take;

  always_comb begin
    cmd_o.accum    = in_take && !in_last_i;
    cmd_o.finish   = in_take && in_last_i;
    cmd_o.div_step = (state_q == ST_DIV);
    cmd_o.load_out = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    if (out_take) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_RUN: begin
        if (in_take && in_last_i) begin
          state_d = ST_DIV;
          cnt_d   = '0;
        end
      end
      ST_DIV: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_RUN;
        end
      end
      default: begin
        state_d = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_last_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> (state_q == ST_DIV) && (cnt_q == '0))
    else $error("last byte did not start the remainder sequence");

  a_div_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) && (cnt_q == CntLast) |=> (state_q == ST_DONE))
    else $error("remainder sequence did not end after the final step");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || !out_stall_i))
    else $error("result loaded over a pending item");

  a_cmd_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.accum, cmd_o.finish, cmd_o.div_step, cmd_o.load_out}))
    else $error("more than one datapath command at once");
`endif

endmodule

// ----- rtl/wsbh_datapath.sv -----
module wsbh_datapath #(
  parameter int unsigned POSITION_BITS = wsbh_pkg::PositionBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  wsbh_pkg::dp_cmd_t              cmd_i,
  input  logic [wsbh_pkg::ByteWidth-1:0] char_byte_i,
  input  logic [wsbh_pkg::DataWidth-1:0] table_size_i,
  input  logic                           fold_case_i,
  output wsbh_pkg::out_item_t            out_item_o
);
  import wsbh_pkg::*;

  // String state.
  logic [DataWidth-1:0]     sum_q, sum_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     ovf_q, ovf_d;

  // Remainder unit: partial remainder and dividend shift register.
  logic [DataWidth:0]   rem_q;
  logic [DataWidth-1:0] quo_q;
  logic                 ovl_hold_q;

  // Output register.
  logic [DataWidth-1:0] bucket_q;
  logic                 overlong_q;

  logic [ByteWidth-1:0] folded;
  logic [DataWidth-1:0] weight;
  logic [DataWidth-1:0] pos_ext;
  logic [DataWidth-1:0] product;
  logic [DataWidth-1:0] sum_next;
  logic [DataWidth:0]   rem_shift;
  logic [DataWidth:0]   divisor_ext;

  always_comb begin
    folded = char_byte_i;
    if (fold_case_i && (char_byte_i >= AsciiUpperFirst) &&
        (char_byte_i <= AsciiUpperLast)) begin
      folded = char_byte_i + AsciiCaseOffset;
    end
  end

  assign weight   = {{(DataWidth-ByteWidth){folded[ByteWidth-1]}}, folded};
  assign pos_ext  = DataWidth'(pos_q);
  assign product  = pos_ext * weight;
  assign sum_next = sum_q + product;

  always_comb begin
    sum_d = sum_q;
    pos_d = pos_q;
    ovf_d = ovf_q;
    if (cmd_i.finish) begin
      sum_d = '0;
      pos_d = '0;
      ovf_d = 1'b0;
    end else if (cmd_i.accum) begin
      sum_d = sum_next;
      pos_d = pos_q + 1'b1;
      if (&pos_q) begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
      pos_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      sum_q <= sum_d;
      pos_q <= pos_d;
      ovf_q <= ovf_d;
    end
  end

  // With a zero divisor every compare succeeds and nothing is subtracted, so
  // after all steps the low word of the remainder is the dividend itself.
  assign rem_shift   = {rem_q[DataWidth-1:0], quo_q[DataWidth-1]};
  assign divisor_ext = {1'b0, table_size_i};

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      rem_q      <= '0;
      quo_q      <= sum_next;
      ovl_hold_q <= ovf_q;
    end else if (cmd_i.div_step) begin
      quo_q <= {quo_q[DataWidth-2:0], 1'b0};
      if (rem_shift >= divisor_ext) begin
        rem_q <= rem_shift - divisor_ext;
      end else begin
        rem_q <= rem_shift;
      end
    end
    if (cmd_i.load_out) begin
      bucket_q   <= rem_q[DataWidth-1:0];
      overlong_q <= ovl_hold_q;
    end
  end

  assign out_item_o.bucket   = bucket_q;
  assign out_item_o.overlong = overlong_q;

endmodule

// ----- rtl/weighted_string_bucket_hash_top.sv -----
// Weighted string bucket hash. The string arrives one byte per item on the
// input channel, the final byte marked by last_byte. Each byte, optionally
// folded from ASCII upper to lower case, is read as a signed char, multiplied
// by its position in the string (the first byte has position 0) and added to
// a wrapping 32-bit sum. Bytes that are not last are taken at one per cycle
// and give no result. The last byte closes the sum and starts a restoring
// remainder unit that retires one dividend bit per cycle. The input stalls
// after each last byte until the remainder is done and has moved into the
// output register once that register is free. The output register lets new
// bytes be taken while a finished result still waits for the far side. The
// result item carries the sum modulo table_size (the full sum when table_size
// is zero) and the overlong flag, which is set when the string ran past the
// range of the POSITION_BITS-wide position counter; later bytes then take
// the wrapped position as their weight. Registers must be written over the
// APB-style port only while the block is idle, which the block itself does
// not enforce: table_size at address 0 and fold_case at address 4. There is
// no start-up sequence after reset.
module weighted_string_bucket_hash_top #(
  parameter int unsigned POSITION_BITS = wsbh_pkg::PositionBitsDefault
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,

  input  logic                           in_valid_i,
  input  wsbh_pkg::in_item_t             in_data_i,
  output logic                           in_stall_o,

  output logic                           out_valid_o,
  output wsbh_pkg::out_item_t            out_data_o,
  input  logic                           out_stall_i,

  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [wsbh_pkg::AddrWidth-1:0] paddr,
  input  logic [wsbh_pkg::DataWidth-1:0] pwdata,
  output logic [wsbh_pkg::DataWidth-1:0] prdata,
  output logic                           pready
);
  import wsbh_pkg::*;

  logic [DataWidth-1:0] table_size_q;
  logic                 fold_case_q;
  logic                 cfg_write;
  logic                 reg_sel;
  dp_cmd_t              cmd;

  // The port never waits; a write lands in the access cycle.
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_size_q <= TableSizeReset;
      fold_case_q  <= FoldCaseReset;
    end else if (cfg_write) begin
      unique case (reg_sel)
        RegTableSize: table_size_q <= pwdata;
        RegFoldCase:  fold_case_q  <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      RegTableSize: prdata = table_size_q;
      RegFoldCase:  prdata = {{(DataWidth-1){1'b0}}, fold_case_q};
      default:      prdata = '0;
    endcase
  end

  // The controller sequences bytes, the remainder steps and the output
  // register; the datapath holds the sum, the position and the remainder.
  wsbh_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_byte),
    .out_stall_i (out_stall_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  wsbh_datapath #(
    .POSITION_BITS (POSITION_BITS)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .char_byte_i  (in_data_i.char_byte),
    .table_size_i (table_size_q),
    .fold_case_i  (fold_case_q),
    .out_item_o   (out_data_o)
  );

endmodule
